[hdl/rpd_pkg.sv]
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and constants shared by the RC receiver pulse decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int KIND_W = 2;
  localparam int CH_W   = 2;
  localparam int TIME_W = 15;
  localparam int VAL_W  = 16;
  localparam int NCH    = 4;

  // divider sizing covers the full parameter ranges (gain up to 16*180)
  localparam int K_W   = 12;
  localparam int MAG_W = 27;
  localparam int DEN_W = 15;
  localparam int CNT_W = $clog2(MAG_W);

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_SEED = 2'd2,
    KIND_NONE = 2'd3
  } rpd_kind_t;

  localparam logic [CH_W-1:0] CH_ROLL     = 2'd0;
  localparam logic [CH_W-1:0] CH_PITCH    = 2'd1;
  localparam logic [CH_W-1:0] CH_THROTTLE = 2'd2;
  localparam logic [CH_W-1:0] CH_YAW      = 2'd3;

  localparam logic [TIME_W-1:0] CAL_CEIL  = 15'd2500;
  localparam logic [TIME_W-1:0] CAL_FLOOR = 15'd500;
  localparam logic [TIME_W-1:0] CAL_SEED  = 15'd1500;
  localparam logic signed [17:0] THR_BASE = 18'sd1000;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_CAL,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_FIN
  } rpd_state_t;

endpackage

[hdl/rpd_if.sv]
// ----------------------------------------------------------------------------
// rpd_in_if / rpd_out_if
// Valid/ready channels carrying decoder requests and decoder results.
// ----------------------------------------------------------------------------
interface rpd_in_if;
  import rpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CH_W-1:0]   channel;
  logic [TIME_W-1:0] capture_time;
  logic [TIME_W-1:0] load_max;
  logic [TIME_W-1:0] load_min;

  modport source (output valid, kind, channel, capture_time, load_max, load_min,
                  input ready);
  modport sink   (input valid, kind, channel, capture_time, load_max, load_min,
                  output ready);
endinterface

interface rpd_out_if;
  import rpd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         channel_out;
  logic                    pulse_done;
  logic [TIME_W-1:0]       pulse_width;
  logic signed [VAL_W-1:0] scaled_value;
  logic                    divide_fault;

  modport source (output valid, channel_out, pulse_done, pulse_width, scaled_value,
                  divide_fault, input ready);
  modport sink   (input valid, channel_out, pulse_done, pulse_width, scaled_value,
                  divide_fault, output ready);
endinterface

[hdl/rc_pwm_receiver_decoder.sv]
// ----------------------------------------------------------------------------
// rc_pwm_receiver_decoder
// Four-channel RC receiver pulse decoder with a shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request per transaction: an edge capture, a
//   calibration load or a calibration seed for one channel. out_chan returns
//   exactly one result transaction per request, in order.
//   cfg_we/cfg_wdata write the calibrate bit; write only while idle.
// Path (request accepted to result valid):
//   rising edge, load, seed, unused kind : output step only
//   throttle pulse or zero-divisor pulse : measure, calibrate, set-up, output
//   roll, pitch, yaw pulse               : adds multiply, divide and fix
//   The divide is the 27-step restoring divider (one quotient bit a cycle
//   through a single subtract/compare).
// Flow: one request at a time; in_chan.ready is high only while the
//   sequencer is idle. A finished result sits in the output register, so the
//   next request is accepted while it waits; the sequencer holds in its final
//   step only if a second result is ready before the first is taken.
// Reset: synchronous, active low. All channels await a rising edge and the
//   calibration max/min return to 1500. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rc_pwm_receiver_decoder #(
  parameter int PERIOD_TICKS = 20000,
  parameter int ANGLE_LIMIT  = 30,
  parameter int RATE_LIMIT   = 200
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rpd_in_if.sink               in_chan,
  rpd_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import rpd_pkg::*;

  localparam logic signed [17:0] PERIOD  = 18'(PERIOD_TICKS);
  localparam logic [K_W-1:0]     ANGLE_K = K_W'(16 * ANGLE_LIMIT);
  localparam logic [K_W-1:0]     RATE_K  = K_W'(RATE_LIMIT);

  rpd_state_t state_r, state_nxt;

  logic                    calibrate_r;
  logic [NCH-1:0]          edge_phase_r;
  logic [TIME_W-1:0]       rise_time_r [NCH];
  logic [TIME_W-1:0]       cal_max_r   [NCH];
  logic [TIME_W-1:0]       cal_min_r   [NCH];

  logic [CH_W-1:0]         ch_r;
  logic [TIME_W-1:0]       time_r;
  logic [TIME_W-1:0]       width_r;
  logic [TIME_W-1:0]       mul_a_r;
  logic [DEN_W-1:0]        den_r;
  logic                    neg_r;
  logic [MAG_W-1:0]        quo_r;
  logic [DEN_W-1:0]        rem_r;
  logic [CNT_W-1:0]        cnt_r;

  logic                    res_done_r;
  logic [TIME_W-1:0]       res_width_r;
  logic signed [VAL_W-1:0] res_value_r;
  logic                    res_fault_r;

  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic                    out_done_r;
  logic [TIME_W-1:0]       out_width_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_fault_r;

  logic                    in_fire;
  logic                    out_load;

  // width with wrap over the timer period
  logic [TIME_W-1:0]       rise_sel;
  logic signed [17:0]      wrap_w;
  logic [TIME_W-1:0]       meas_w;

  // scaling set-up
  logic [TIME_W-1:0]       mx, mn;
  logic [TIME_W:0]         mm_sum;
  logic [TIME_W-1:0]       mid;
  logic signed [TIME_W:0]  den;
  logic signed [TIME_W+1:0] diff;
  logic [TIME_W-1:0]       diff_mag;
  logic [DEN_W-1:0]        den_mag;
  logic signed [17:0]      thr;
  logic signed [VAL_W-1:0] thr_sat;

  // shared divider step
  logic [DEN_W:0]          trial;
  logic                    q_bit;
  logic [DEN_W:0]          trial_diff;

  logic [K_W-1:0]          gain;
  logic signed [VAL_W-1:0] quo_sat;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.channel_out  = out_ch_r;
  assign out_chan.pulse_done   = out_done_r;
  assign out_chan.pulse_width  = out_width_r;
  assign out_chan.scaled_value = out_value_r;
  assign out_chan.divide_fault = out_fault_r;

  always_comb begin
    rise_sel = rise_time_r[ch_r];
    wrap_w   = PERIOD + $signed({3'b000, time_r}) - $signed({3'b000, rise_sel});
    if (time_r >= rise_sel) begin
      meas_w = time_r - rise_sel;
    end else if (wrap_w[17]) begin
      meas_w = '0;
    end else if (wrap_w > 18'sd32767) begin
      meas_w = '1;
    end else begin
      meas_w = wrap_w[TIME_W-1:0];
    end
  end

  always_comb begin
    mx       = cal_max_r[ch_r];
    mn       = cal_min_r[ch_r];
    mm_sum   = {1'b0, mx} + {1'b0, mn};
    mid      = mm_sum[TIME_W:1];
    den      = $signed({1'b0, mid}) - $signed({1'b0, mn});
    diff     = $signed({2'b00, width_r}) - $signed({2'b00, mid});
    diff_mag = diff[TIME_W+1] ? TIME_W'(-diff) : diff[TIME_W-1:0];
    den_mag  = den[TIME_W] ? DEN_W'(-den) : den[DEN_W-1:0];
    thr      = THR_BASE + $signed({3'b000, width_r}) - $signed({3'b000, mn});
    if (thr > 18'sd32767) begin
      thr_sat = VAL_MAX;
    end else if (thr < -18'sd32768) begin
      thr_sat = VAL_MIN;
    end else begin
      thr_sat = thr[VAL_W-1:0];
    end
  end

  always_comb begin
    trial      = {rem_r, quo_r[MAG_W-1]};
    q_bit      = (trial >= {1'b0, den_r});
    trial_diff = trial - {1'b0, den_r};
    gain       = (ch_r == CH_YAW) ? RATE_K : ANGLE_K;
    if (neg_r) begin
      quo_sat = (quo_r > MAG_W'(32768)) ? VAL_MIN : VAL_W'(MAG_W'(0) - quo_r);
    end else begin
      quo_sat = (quo_r > MAG_W'(32767)) ? VAL_MAX : quo_r[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (rpd_kind_t'(in_chan.kind) == KIND_EDGE && edge_phase_r[in_chan.channel]) begin
            state_nxt = ST_EDGE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_EDGE: state_nxt = ST_CAL;
      ST_CAL:  state_nxt = ST_PREP;
      ST_PREP: begin
        if (ch_r == CH_THROTTLE || den == '0) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and calibration tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrate_r  <= 1'b0;
      edge_phase_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        cal_max_r[i] <= CAL_SEED;
        cal_min_r[i] <= CAL_SEED;
      end
    end else begin
      if (cfg_we) begin
        calibrate_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        case (rpd_kind_t'(in_chan.kind))
          KIND_EDGE: edge_phase_r[in_chan.channel] <= ~edge_phase_r[in_chan.channel];
          KIND_LOAD: begin
            cal_max_r[in_chan.channel] <= in_chan.load_max;
            cal_min_r[in_chan.channel] <= in_chan.load_min;
          end
          KIND_SEED: begin
            cal_max_r[in_chan.channel] <= CAL_SEED;
            cal_min_r[in_chan.channel] <= CAL_SEED;
          end
          default: ;
        endcase
      end
      if (state_r == ST_CAL && calibrate_r) begin
        if (width_r > cal_max_r[ch_r] && width_r <= CAL_CEIL) begin
          cal_max_r[ch_r] <= width_r;
        end
        if (width_r < cal_min_r[ch_r] && width_r >= CAL_FLOOR) begin
          cal_min_r[ch_r] <= width_r;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ch_r        <= in_chan.channel;
          time_r      <= in_chan.capture_time;
          res_done_r  <= 1'b0;
          res_width_r <= '0;
          res_value_r <= '0;
          res_fault_r <= 1'b0;
          if (rpd_kind_t'(in_chan.kind) == KIND_EDGE && !edge_phase_r[in_chan.channel]) begin
            rise_time_r[in_chan.channel] <= in_chan.capture_time;
          end
        end
      end
      ST_EDGE: begin
        width_r     <= meas_w;
        res_done_r  <= 1'b1;
        res_width_r <= meas_w;
      end
      ST_PREP: begin
        mul_a_r <= diff_mag;
        den_r   <= den_mag;
        neg_r   <= diff[TIME_W+1] ^ den[TIME_W] ^ (ch_r == CH_ROLL);
        if (ch_r == CH_THROTTLE) begin
          res_value_r <= thr_sat;
        end else if (den == '0) begin
          res_fault_r <= 1'b1;
        end
      end
      ST_MUL: begin
        quo_r <= MAG_W'(mul_a_r * gain);
        rem_r <= '0;
        cnt_r <= CNT_W'(MAG_W - 1);
      end
      ST_DIV: begin
        // one restoring step: shift in a dividend bit, subtract if it fits
        rem_r <= q_bit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_r <= {quo_r[MAG_W-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_FIX: res_value_r <= quo_sat;
      default: ;
    endcase
    if (out_load) begin
      out_ch_r    <= ch_r;
      out_done_r  <= res_done_r;
      out_width_r <= res_width_r;
      out_value_r <= res_value_r;
      out_fault_r <= res_fault_r;
    end
  end

endmodule

[hdl/rpd_checker.sv]
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks for the RC receiver pulse decoder, bound to the top.
// ----------------------------------------------------------------------------
module rpd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               channel_out,
  input logic                     pulse_done,
  input logic [14:0]              pulse_width,
  input logic signed [15:0]       scaled_value,
  input logic                     divide_fault
);
  import rpd_pkg::*;

  // a result held back by the sink keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(channel_out) &&
      $stable(pulse_done) && $stable(pulse_width) && $stable(scaled_value) &&
      $stable(divide_fault))
    else $error("result changed while stalled");

  // one request at a time: the sequencer is busy after a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pulse_done |-> pulse_width == '0 && scaled_value == '0 &&
      !divide_fault)
    else $error("non-pulse result carries data");

  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divide_fault |-> scaled_value == '0 && pulse_done &&
      channel_out != CH_THROTTLE)
    else $error("bad divide fault result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rc_pwm_receiver_decoder rpd_checker u_rpd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .channel_out  (out_chan.channel_out),
  .pulse_done   (out_chan.pulse_done),
  .pulse_width  (out_chan.pulse_width),
  .scaled_value (out_chan.scaled_value),
  .divide_fault (out_chan.divide_fault)
);

[sim/rc_pwm_receiver_decoder_test.sv]
// ----------------------------------------------------------------------------
// rc_pwm_receiver_decoder_test
// Self-checking bench for the four-channel RC pulse decoder. Requests are
// queued by a stimulus process and driven by a clocked driver. Each accepted
// transaction is decoded by a local model of the block, and a clocked monitor
// compares every result transaction, field by field, with the oldest decoded
// value. Directed corner cases come first, then random requests in four phases
// alternating calibrate on/off, with random idling and one long output stall.
// ----------------------------------------------------------------------------
module rc_pwm_receiver_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpd_pkg::*;

  localparam int PERIOD_TICKS = 20000;
  localparam int ANGLE_LIMIT  = 30;
  localparam int RATE_LIMIT   = 200;
  localparam int IDLE_PCT     = 34;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AT      = 700;
  localparam int PHASE_ITEMS  = 490;

  typedef struct packed {
    rpd_kind_t         kind;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] capture_time;
    logic [TIME_W-1:0] load_max;
    logic [TIME_W-1:0] load_min;
  } pulse_req_t;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic                    done;
    logic [TIME_W-1:0]       width;
    logic signed [VAL_W-1:0] scaled;
    logic                    fault;
  } pulse_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  rpd_in_if  in_chan ();
  rpd_out_if out_chan ();

  rc_pwm_receiver_decoder #(
    .PERIOD_TICKS (PERIOD_TICKS),
    .ANGLE_LIMIT  (ANGLE_LIMIT),
    .RATE_LIMIT   (RATE_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // decoder model state
  logic              calib_on;
  logic              phase_r [NCH];
  logic [TIME_W-1:0] rise_r  [NCH];
  logic [TIME_W-1:0] cal_hi  [NCH];
  logic [TIME_W-1:0] cal_lo  [NCH];

  // stimulus-side view of each channel's edge phase
  logic              gen_phase [NCH];
  int                gen_rise  [NCH];

  pulse_req_t  req_queue [$];
  pulse_res_t  decoded_queue [$];
  pulse_req_t  on_bus;

  int unsigned reqs_pushed;
  int unsigned reqs_taken;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned stall_cycles;
  int unsigned hold_left;
  bit          hold_done;
  bit          steady;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [VAL_W-1:0] clamp16(longint v);
    if (v > 32767) return VAL_MAX;
    if (v < -32768) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  function automatic pulse_res_t decode_request(pulse_req_t rq);
    pulse_res_t res;
    longint     w, mx, mn, mid, den, num;
    int         c;
    res = '0;
    res.ch = rq.channel;
    c = rq.channel;
    case (rq.kind)
      KIND_EDGE: begin
        if (!phase_r[c]) begin
          rise_r[c]  = rq.capture_time;
          phase_r[c] = 1'b1;
        end else begin
          if (rq.capture_time < rise_r[c])
            w = longint'(PERIOD_TICKS) - longint'(rise_r[c]) + longint'(rq.capture_time);
          else
            w = longint'(rq.capture_time) - longint'(rise_r[c]);
          if (w < 0) w = 0;
          if (w > 32767) w = 32767;
          res.width  = w[TIME_W-1:0];
          res.done   = 1'b1;
          phase_r[c] = 1'b0;
          if (calib_on) begin
            if (res.width > cal_hi[c] && res.width <= CAL_CEIL) cal_hi[c] = res.width;
            if (res.width < cal_lo[c] && res.width >= CAL_FLOOR) cal_lo[c] = res.width;
          end
          mx  = cal_hi[c];
          mn  = cal_lo[c];
          mid = (mx + mn) / 2;
          den = mid - mn;
          if (rq.channel == CH_THROTTLE) begin
            res.scaled = clamp16(longint'(THR_BASE) + w - mn);
          end else if (den == 0) begin
            res.fault = 1'b1;
          end else if (rq.channel == CH_YAW) begin
            num = longint'(RATE_LIMIT) * (w - mid);
            res.scaled = clamp16(num / den);
          end else begin
            num = longint'(ANGLE_LIMIT) * 16 * (w - mid);
            // roll is reported with the opposite sign
            if (rq.channel == CH_ROLL) res.scaled = clamp16(-(num / den));
            else res.scaled = clamp16(num / den);
          end
        end
      end
      KIND_LOAD: begin
        cal_hi[c] = rq.load_max;
        cal_lo[c] = rq.load_min;
      end
      KIND_SEED: begin
        cal_hi[c] = CAL_SEED;
        cal_lo[c] = CAL_SEED;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic add_request(rpd_kind_t k, logic [CH_W-1:0] ch, int t, int lmax, int lmin);
    pulse_req_t rq;
    rq.kind         = k;
    rq.channel      = ch;
    rq.capture_time = t[TIME_W-1:0];
    rq.load_max     = lmax[TIME_W-1:0];
    rq.load_min     = lmin[TIME_W-1:0];
    if (k == KIND_EDGE) begin
      if (!gen_phase[ch]) gen_rise[ch] = t[TIME_W-1:0];
      gen_phase[ch] = !gen_phase[ch];
    end
    req_queue.push_back(rq);
    reqs_pushed++;
  endtask

  // Mostly well-formed rising/falling pairs with plausible widths, plus
  // loads, seeds, unused kinds and edges at arbitrary counts as noise.
  task automatic rand_request();
    int              r, w, t, lmax, lmin;
    logic [CH_W-1:0] ch;
    r    = $urandom_range(99);
    ch   = CH_W'($urandom_range(NCH - 1));
    t    = $urandom_range(32767);
    lmax = $urandom_range(32767);
    lmin = $urandom_range(32767);
    if (r < 80) begin
      if (!gen_phase[ch]) begin
        t = $urandom_range(PERIOD_TICKS - 1);
      end else begin
        if ($urandom_range(99) < 90) w = $urandom_range(2700, 800);
        else w = $urandom_range(6000);
        t = (gen_rise[ch] + w) % PERIOD_TICKS;
      end
      add_request(KIND_EDGE, ch, t, lmax, lmin);
    end else if (r < 83) begin
      add_request(KIND_EDGE, ch, t, lmax, lmin);
    end else if (r < 91) begin
      if ($urandom_range(99) < 80) begin
        lmax = $urandom_range(2500, 1600);
        lmin = $urandom_range(1400, 500);
      end
      add_request(KIND_LOAD, ch, t, lmax, lmin);
    end else if (r < 96) begin
      add_request(KIND_SEED, ch, t, lmax, lmin);
    end else begin
      add_request(KIND_NONE, ch, t, lmax, lmin);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (!(reqs_taken == reqs_pushed && results_seen == reqs_taken)) @(posedge clk);
  endtask

  task automatic set_calibrate(logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    calib_on   = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        decoded_queue.push_back(decode_request(on_bus));
        reqs_taken++;
      end
      if (in_chan.valid && !in_chan.ready) begin
        // hold the transaction until taken
      end else if (req_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        on_bus = req_queue.pop_front();
        in_chan.valid        <= 1'b1;
        in_chan.kind         <= on_bus.kind;
        in_chan.channel      <= on_bus.channel;
        in_chan.capture_time <= on_bus.capture_time;
        in_chan.load_max     <= on_bus.load_max;
        in_chan.load_min     <= on_bus.load_min;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    pulse_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (decoded_queue.size() == 0) begin
        $display("%0t ns: result with nothing outstanding, channel %0d", $time,
                 out_chan.channel_out);
        errors++;
      end else begin
        want = decoded_queue.pop_front();
        check_field("channel_out", want.ch, out_chan.channel_out);
        check_field("pulse_done", want.done, out_chan.pulse_done);
        check_field("pulse_width", want.width, out_chan.pulse_width);
        check_field("scaled_value", $signed(want.scaled), $signed(out_chan.scaled_value));
        check_field("divide_fault", want.fault, out_chan.divide_fault);
      end
      results_seen++;
    end
    // one long hold-off so the block backs up onto its input
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.kind         = KIND_EDGE;
    in_chan.channel      = '0;
    in_chan.capture_time = '0;
    in_chan.load_max     = '0;
    in_chan.load_min     = '0;
    out_chan.ready       = 1'b0;
    calib_on             = 1'b0;
    reqs_pushed          = 0;
    reqs_taken           = 0;
    results_seen         = 0;
    errors               = 0;
    stall_cycles         = 0;
    hold_left            = 0;
    hold_done            = 1'b0;
    steady               = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      phase_r[i]   = 1'b0;
      rise_r[i]    = '0;
      cal_hi[i]    = CAL_SEED;
      cal_lo[i]    = CAL_SEED;
      gen_phase[i] = 1'b0;
      gen_rise[i]  = 0;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero divisor after reset, throttle, unused kind
    add_request(KIND_EDGE, CH_ROLL, 0, 0, 0);
    add_request(KIND_EDGE, CH_ROLL, 1500, 0, 0);
    add_request(KIND_EDGE, CH_THROTTLE, 100, 0, 0);
    add_request(KIND_EDGE, CH_THROTTLE, 1100, 0, 0);
    add_request(KIND_NONE, CH_PITCH, 32767, 32767, 32767);
    // wrap over the period on roll
    add_request(KIND_LOAD, CH_ROLL, 0, 2000, 1000);
    add_request(KIND_EDGE, CH_ROLL, 19000, 0, 0);
    add_request(KIND_EDGE, CH_ROLL, 1000, 0, 0);
    // counts beyond the period: negative width clamps to zero, widest pulse
    add_request(KIND_LOAD, CH_PITCH, 0, 2000, 1000);
    add_request(KIND_EDGE, CH_PITCH, 32767, 0, 0);
    add_request(KIND_EDGE, CH_PITCH, 0, 0, 0);
    add_request(KIND_EDGE, CH_PITCH, 0, 0, 0);
    add_request(KIND_EDGE, CH_PITCH, 32767, 0, 0);
    // min above max gives a negative divisor
    add_request(KIND_LOAD, CH_YAW, 0, 1000, 3000);
    add_request(KIND_EDGE, CH_YAW, 500, 0, 0);
    add_request(KIND_EDGE, CH_YAW, 1500, 0, 0);
    // saturation low on roll, high on throttle
    add_request(KIND_LOAD, CH_ROLL, 0, 1002, 1000);
    add_request(KIND_EDGE, CH_ROLL, 0, 0, 0);
    add_request(KIND_EDGE, CH_ROLL, 32767, 0, 0);
    add_request(KIND_LOAD, CH_THROTTLE, 0, 0, 0);
    add_request(KIND_EDGE, CH_THROTTLE, 0, 0, 0);
    add_request(KIND_EDGE, CH_THROTTLE, 32767, 0, 0);
    // seed restores 1500/1500, zero-width pulse then faults
    add_request(KIND_SEED, CH_YAW, 0, 0, 0);
    add_request(KIND_EDGE, CH_YAW, 10, 0, 0);
    add_request(KIND_EDGE, CH_YAW, 10, 0, 0);

    wait_drained();
    set_calibrate(1'b1);
    repeat (PHASE_ITEMS) rand_request();

    wait_drained();
    set_calibrate(1'b0);
    repeat (PHASE_ITEMS) rand_request();

    // no idling on either side through this setting
    wait_drained();
    set_calibrate(1'b1);
    steady = 1'b1;
    repeat (PHASE_ITEMS) rand_request();
    wait_drained();
    steady = 1'b0;

    set_calibrate(1'b0);
    repeat (PHASE_ITEMS) rand_request();

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && decoded_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
